// ===== src/fed_pkg.sv =====
// Shared types, constants and arithmetic helpers for the feedback echo delay.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package fed_pkg;

    // Defaults for the top-level parameters
    localparam int STORE_ADDR_BITS_DEF = 18;
    localparam int SAMPLE_RATE_DEF     = 48000;

    // Field and register widths
    localparam int SAMPLE_W    = 16;
    localparam int GAIN_W      = 5;
    localparam int DELAY_MS_W  = 13;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 3;

    // Register reset values
    localparam int DELAY_MS_RESET    = 401;
    localparam int BLEND_RESET       = 10;
    localparam int FEEDFORWARD_RESET = 5;
    localparam int FEEDBACK_RESET    = 5;
    localparam int LOOPER_RESET      = 0;

    // Milliseconds per second, divisor of the delay conversion
    localparam int MS_PER_S = 1000;

    // Gain k/20: product magnitude, reciprocal multiply and scaled result widths
    localparam int GAIN_DEN    = 20;
    localparam int MAG_W       = 20;
    localparam int PROD_W      = MAG_W + 1;
    localparam int GAIN_SHIFT  = 24;
    localparam int GAIN_RECIP  = (2 ** GAIN_SHIFT + GAIN_DEN - 1) / GAIN_DEN;
    localparam int RECIP_W     = $clog2(GAIN_RECIP + 1);
    localparam int QUO_W       = 16;
    localparam int SCALED_W    = QUO_W + 1;
    localparam int SUM_W       = SCALED_W + 1;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DELAY_MS         = 3'd0,
        REG_BLEND_GAIN       = 3'd1,
        REG_FEEDFORWARD_GAIN = 3'd2,
        REG_FEEDBACK_GAIN    = 3'd3,
        REG_LOOPER_MODE      = 3'd4
    } cfg_reg_t;

    // Gain settings seen by the datapath
    typedef struct packed {
        logic [GAIN_W-1:0] blend;
        logic [GAIN_W-1:0] feedforward;
        logic [GAIN_W-1:0] feedback;
        logic              looper_mode;
    } gains_t;

    // Sign and magnitude of a gain product k * x
    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } gain_prod_t;

    // Item handed from the feedback loop to the output mix
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] xh;
        logic signed [SCALED_W-1:0] ff;
    } mix_item_t;

    // Multiply a sample by a gain numerator, split into sign and magnitude
    function automatic gain_prod_t gain_mult(input logic [GAIN_W-1:0] k,
                                             input logic signed [SAMPLE_W-1:0] x);
        logic signed [PROD_W-1:0] p;
        gain_prod_t r;
        p = $signed({1'b0, k}) * x;
        r.neg = p[PROD_W-1];
        r.mag = r.neg ? MAG_W'(-p) : MAG_W'(p);
        return r;
    endfunction

    // Divide a gain product by 20, truncated toward zero (reciprocal multiply)
    function automatic logic signed [SCALED_W-1:0] gain_scale(input gain_prod_t p);
        logic [MAG_W+RECIP_W-1:0] wide;
        logic [QUO_W-1:0] q;
        wide = (MAG_W + RECIP_W)'(p.mag) * (MAG_W + RECIP_W)'(GAIN_RECIP);
        q = QUO_W'(wide >> GAIN_SHIFT);
        return p.neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    endfunction

    // Saturate a sum to the signed sample range
    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
        if (v[SUM_W-1:SAMPLE_W-1] == '0 || v[SUM_W-1:SAMPLE_W-1] == '1)
        begin
            return v[SAMPLE_W-1:0];
        end
        return v[SUM_W-1] ? SAMPLE_MIN : SAMPLE_MAX;
    endfunction

endpackage

// ===== src/fed_in_if.sv =====
// Input sample channel: valid/ready handshake with one signed sample.
// Depends on fed_pkg for the sample width.
`timescale 1ns / 1ps

interface fed_in_if;
    import fed_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

// ===== src/fed_out_if.sv =====
// Output sample channel: valid/ready handshake with one signed sample.
// Depends on fed_pkg for the sample width.
`timescale 1ns / 1ps

interface fed_out_if;
    import fed_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

// ===== src/fed_delay_calc.sv =====
// Converts the delay in milliseconds to a delay in samples by reciprocal multiplication.
// Depends on fed_pkg; after a delay_ms write the products pass stages 1 and 2 before the final delay register loads.
`timescale 1ns / 1ps

module fed_delay_calc #(
    parameter int STORE_ADDR_BITS = fed_pkg::STORE_ADDR_BITS_DEF,
    parameter int SAMPLE_RATE     = fed_pkg::SAMPLE_RATE_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [fed_pkg::DELAY_MS_W-1:0]   delay_ms,
    output logic                             busy,
    output logic [STORE_ADDR_BITS-1:0]       delay_samples
);
    import fed_pkg::*;

    localparam int PROD_W  = DELAY_MS_W + $clog2(SAMPLE_RATE + 1);
    // Whole and leftover samples per millisecond
    localparam int RATE_Q  = SAMPLE_RATE / MS_PER_S;
    localparam int RATE_R  = SAMPLE_RATE % MS_PER_S;
    localparam int MS_BITS = $clog2(MS_PER_S);
    localparam int PART_W  = DELAY_MS_W + MS_BITS;
    // Reciprocal of the millisecond divisor, exact for every PART_W-bit dividend
    localparam int SHIFT   = PART_W + MS_BITS;
    localparam int RECIP_W = PART_W + 1;
    localparam int SCALE_W = PART_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + 64'(MS_PER_S) - 64'd1) / 64'(MS_PER_S));
    localparam logic [PROD_W-1:0] RESET_QUO =
        PROD_W'(DELAY_MS_RESET * SAMPLE_RATE / MS_PER_S);

    logic                s1_valid_reg;
    logic [PROD_W-1:0]   s1_whole_reg;
    logic [PART_W-1:0]   s1_part_reg;
    logic                s2_valid_reg;
    logic [PROD_W-1:0]   s2_whole_reg;
    logic [PROD_W-1:0]   s2_frac_reg;
    logic [PROD_W-1:0]   quo_reg;
    logic [SCALE_W-1:0]  part_scaled;

    assign busy          = s1_valid_reg || s2_valid_reg;
    assign delay_samples = quo_reg[STORE_ADDR_BITS-1:0];

    // Divide the leftover product by the millisecond count
    assign part_scaled = SCALE_W'(s1_part_reg) * SCALE_W'(RECIP);

    // Advance the conversion valid bits and load the final delay
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            quo_reg      <= RESET_QUO;
        end
        else
        begin
            s1_valid_reg <= start;
            s2_valid_reg <= s1_valid_reg;
            if (s2_valid_reg)
            begin
                quo_reg <= s2_whole_reg + s2_frac_reg;
            end
        end
    end

    // Split products on a write, then the scaled leftover
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            s1_whole_reg <= PROD_W'(delay_ms) * PROD_W'(RATE_Q);
            s1_part_reg  <= PART_W'(delay_ms) * PART_W'(RATE_R);
        end
        if (s1_valid_reg)
        begin
            s2_whole_reg <= s1_whole_reg;
            s2_frac_reg  <= PROD_W'(part_scaled >> SHIFT);
        end
    end

endmodule

// ===== src/fed_feedback_loop.sv =====
// Delay store, write pointer and the feedback path up to the store write.
// Depends on fed_pkg and fed_in_if; feeds fed_output_mix through a valid/ready link.
`timescale 1ns / 1ps

module fed_feedback_loop #(
    parameter int STORE_ADDR_BITS = fed_pkg::STORE_ADDR_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    fed_in_if.sink                      in_stream,
    input  logic [STORE_ADDR_BITS-1:0]  delay_samples,
    input  logic                        delay_busy,
    input  fed_pkg::gains_t             gains,
    output logic                        link_valid,
    input  logic                        link_ready,
    output fed_pkg::mix_item_t          link_item
);
    import fed_pkg::*;

    localparam int DEPTH = 1 << STORE_ADDR_BITS;

    typedef logic [STORE_ADDR_BITS-1:0] addr_t;

    // Delay store, no reset: unwritten entries are masked by the fill tracking
    logic [SAMPLE_W-1:0] store_mem [DEPTH];
    logic [SAMPLE_W-1:0] rdata_reg;

    // Pointer and fill tracking
    addr_t wp_reg;
    logic  wrapped_reg;
    addr_t rd_addr;
    logic  entry_ok;
    logic  hazard;
    logic  accept;

    // Stage 1: read data arrives
    logic                       s1_valid_reg;
    logic signed [SAMPLE_W-1:0] s1_x_reg;
    addr_t                      s1_wa_reg;
    logic                       s1_ok_reg;
    logic signed [SAMPLE_W-1:0] s1_d;
    logic                       s1_ready;

    // Stage 2: gain products
    logic                       s2_valid_reg;
    logic signed [SAMPLE_W-1:0] s2_x_reg;
    addr_t                      s2_wa_reg;
    gain_prod_t                 s2_fb_reg;
    gain_prod_t                 s2_ff_reg;
    logic                       s2_ready;

    // Stage 3: scaled terms, feedback sum and store write
    logic                       s3_valid_reg;
    logic signed [SAMPLE_W-1:0] s3_x_reg;
    addr_t                      s3_wa_reg;
    logic signed [SCALED_W-1:0] s3_fb_reg;
    logic signed [SCALED_W-1:0] s3_ff_reg;
    logic signed [SUM_W-1:0]    s3_sum;
    logic signed [SAMPLE_W-1:0] s3_xh;
    logic signed [SAMPLE_W-1:0] s3_store;
    logic                       s3_ready;
    logic                       store_wr;

    // Read address and whether that entry was ever written since reset
    assign rd_addr  = wp_reg - delay_samples;
    assign entry_ok = wrapped_reg || (rd_addr < wp_reg);

    // Hold input while an in-flight item still has to write the entry we would read
    assign hazard = (s1_valid_reg && s1_wa_reg == rd_addr)
                 || (s2_valid_reg && s2_wa_reg == rd_addr)
                 || (s3_valid_reg && s3_wa_reg == rd_addr);

    assign s3_ready = !s3_valid_reg || link_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;

    assign in_stream.ready = s1_ready && !delay_busy && !hazard;
    assign accept          = in_stream.valid && in_stream.ready;

    // Advance the write pointer on each transfer; note the first wrap
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg      <= '0;
            wrapped_reg <= 1'b0;
        end
        else if (accept)
        begin
            wp_reg <= wp_reg + 1'b1;
            if (wp_reg == '1)
            begin
                wrapped_reg <= 1'b1;
            end
        end
    end

    // Store port: read at transfer, write as stage 3 hands its item on
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rdata_reg <= store_mem[rd_addr];
        end
        if (store_wr)
        begin
            store_mem[s3_wa_reg] <= s3_store;
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= accept;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Unwritten entries read as zero
    assign s1_d = s1_ok_reg ? $signed(rdata_reg) : '0;

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_x_reg  <= in_stream.sample_in;
            s1_wa_reg <= wp_reg;
            s1_ok_reg <= entry_ok;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_x_reg  <= s1_x_reg;
            s2_wa_reg <= s1_wa_reg;
            s2_fb_reg <= gain_mult(gains.feedback, s1_d);
            s2_ff_reg <= gain_mult(gains.feedforward, s1_d);
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_x_reg  <= s2_x_reg;
            s3_wa_reg <= s2_wa_reg;
            s3_fb_reg <= gain_scale(s2_fb_reg);
            s3_ff_reg <= gain_scale(s2_ff_reg);
        end
    end

    // Feedback sum; looper mode keeps the input out of the store
    always_comb
    begin
        s3_sum   = $signed(SUM_W'(s3_x_reg)) + $signed(SUM_W'(s3_fb_reg));
        s3_xh    = sat16(s3_sum);
        s3_store = gains.looper_mode ? sat16($signed(SUM_W'(s3_fb_reg))) : s3_xh;
    end

    assign store_wr     = s3_valid_reg && link_ready;
    assign link_valid   = s3_valid_reg;
    assign link_item.xh = s3_xh;
    assign link_item.ff = s3_ff_reg;

endmodule

// ===== src/fed_output_mix.sv =====
// Output mix: blend gain on the feedback sum, add the feed-forward term, saturate.
// Depends on fed_pkg and fed_out_if; takes items from fed_feedback_loop.
`timescale 1ns / 1ps

module fed_output_mix (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              link_valid,
    output logic                              link_ready,
    input  fed_pkg::mix_item_t                link_item,
    input  logic [fed_pkg::GAIN_W-1:0]        blend_gain,
    fed_out_if.source                         out_stream
);
    import fed_pkg::*;

    // Stage 4: blend product
    logic                       s4_valid_reg;
    gain_prod_t                 s4_bl_reg;
    logic signed [SCALED_W-1:0] s4_ff_reg;
    logic                       s4_ready;

    // Stage 5: scaled blend term
    logic                       s5_valid_reg;
    logic signed [SCALED_W-1:0] s5_bl_reg;
    logic signed [SCALED_W-1:0] s5_ff_reg;
    logic                       s5_ready;

    // Output register
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_sample_reg;
    logic                       out_ready;

    assign out_ready  = !out_valid_reg || out_stream.ready;
    assign s5_ready   = !s5_valid_reg || out_ready;
    assign s4_ready   = !s4_valid_reg || s5_ready;
    assign link_ready = s4_ready;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s4_ready)
            begin
                s4_valid_reg <= link_valid;
            end
            if (s5_ready)
            begin
                s5_valid_reg <= s4_valid_reg;
            end
            if (out_ready)
            begin
                out_valid_reg <= s5_valid_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s4_ready && link_valid)
        begin
            s4_bl_reg <= gain_mult(blend_gain, link_item.xh);
            s4_ff_reg <= link_item.ff;
        end
        if (s5_ready && s4_valid_reg)
        begin
            s5_bl_reg <= gain_scale(s4_bl_reg);
            s5_ff_reg <= s4_ff_reg;
        end
        if (out_ready && s5_valid_reg)
        begin
            out_sample_reg <= sat16($signed(SUM_W'(s5_ff_reg)) + $signed(SUM_W'(s5_bl_reg)));
        end
    end

    assign out_stream.valid      = out_valid_reg;
    assign out_stream.sample_out = out_sample_reg;

endmodule

// ===== src/feedback_echo_delay.sv =====
// Feedback echo delay top level: config registers, delay conversion, loop and mix.
// Path: loop stages 1-3, mix stages 4-5, output register; one sample per cycle sustained
// without stalls. Input stalls while the delay conversion runs after a delay_ms write,
// and when the delay modulo the store depth
// is 1 to 3 samples, until the item writing the needed entry leaves stage 3.
// Reset: registers take their defaults; the store is not swept, unwritten entries read zero.
`timescale 1ns / 1ps

module feedback_echo_delay #(
    parameter int STORE_ADDR_BITS = fed_pkg::STORE_ADDR_BITS_DEF,
    parameter int SAMPLE_RATE     = fed_pkg::SAMPLE_RATE_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    fed_in_if.sink                             in_stream,
    fed_out_if.source                          out_stream,
    input  logic                               cfg_wr_en,
    input  logic [fed_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [fed_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import fed_pkg::*;

    logic [GAIN_W-1:0]          blend_gain_reg;
    logic [GAIN_W-1:0]          feedforward_gain_reg;
    logic [GAIN_W-1:0]          feedback_gain_reg;
    logic                       looper_mode_reg;
    gains_t                     gains;
    logic                       delay_start;
    logic                       delay_busy;
    logic [STORE_ADDR_BITS-1:0] delay_samples;
    logic                       link_valid;
    logic                       link_ready;
    mix_item_t                  link_item;

    // Gain and mode registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_gain_reg       <= GAIN_W'(BLEND_RESET);
            feedforward_gain_reg <= GAIN_W'(FEEDFORWARD_RESET);
            feedback_gain_reg    <= GAIN_W'(FEEDBACK_RESET);
            looper_mode_reg      <= 1'(LOOPER_RESET);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_BLEND_GAIN:       blend_gain_reg       <= cfg_wdata[GAIN_W-1:0];
                REG_FEEDFORWARD_GAIN: feedforward_gain_reg <= cfg_wdata[GAIN_W-1:0];
                REG_FEEDBACK_GAIN:    feedback_gain_reg    <= cfg_wdata[GAIN_W-1:0];
                REG_LOOPER_MODE:      looper_mode_reg      <= cfg_wdata[0];
                default:              ;
            endcase
        end
    end

    assign delay_start       = cfg_wr_en && (cfg_index == REG_DELAY_MS);
    assign gains.blend       = blend_gain_reg;
    assign gains.feedforward = feedforward_gain_reg;
    assign gains.feedback    = feedback_gain_reg;
    assign gains.looper_mode = looper_mode_reg;

    fed_delay_calc #(
        .STORE_ADDR_BITS (STORE_ADDR_BITS),
        .SAMPLE_RATE     (SAMPLE_RATE)
    ) u_delay_calc (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (delay_start),
        .delay_ms      (cfg_wdata[DELAY_MS_W-1:0]),
        .busy          (delay_busy),
        .delay_samples (delay_samples)
    );

    fed_feedback_loop #(
        .STORE_ADDR_BITS (STORE_ADDR_BITS)
    ) u_feedback_loop (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_stream     (in_stream),
        .delay_samples (delay_samples),
        .delay_busy    (delay_busy),
        .gains         (gains),
        .link_valid    (link_valid),
        .link_ready    (link_ready),
        .link_item     (link_item)
    );

    fed_output_mix u_output_mix (
        .clk        (clk),
        .rst_n      (rst_n),
        .link_valid (link_valid),
        .link_ready (link_ready),
        .link_item  (link_item),
        .blend_gain (gains.blend),
        .out_stream (out_stream)
    );

endmodule
